// ===== hdl/accumulator_alu_with_undo_stack_macros.svh =====
// Assertion helpers, all sampled on clk_i and disabled while rst_ni is low.
`ifndef ACCUMULATOR_ALU_WITH_UNDO_STACK_MACROS_SVH
`define ACCUMULATOR_ALU_WITH_UNDO_STACK_MACROS_SVH

// Condition must hold at every edge.
`define ACCALU_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ACCALU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ACCALU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/accalu_pkg.sv =====
`default_nettype none
package accalu_pkg;

  localparam int unsigned DefaultDepth = 256;
  localparam int unsigned DataW        = 32;
  localparam int unsigned FieldCntW    = 9;
  localparam int unsigned Steps        = 32;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_APPLY = 2'd1;
  localparam logic [1:0] CMD_UNDO  = 2'd2;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DIV0  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic             start;
    logic [1:0]       opcode;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] result;
  } alu_rsp_t;

endpackage
`default_nettype wire

// ===== hdl/accalu_unit.sv =====
`default_nettype none
// Shared arithmetic unit: add/sub computed directly, multiply by shift-add and
// divide by restoring subtraction, one bit per cycle on a single adder.
module accalu_unit (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire accalu_pkg::alu_req_t req_i,
  output      accalu_pkg::alu_rsp_t rsp_o
);

  localparam int unsigned W    = accalu_pkg::DataW;
  localparam int unsigned CntW = $clog2(accalu_pkg::Steps);

  logic            busy_q, busy_d;
  logic            fix_q, fix_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            mul_q, mul_d;
  logic            neg_q, neg_d;
  logic [W-1:0]    acc_q, acc_d;
  logic [W-1:0]    x_q, x_d;
  logic [W-1:0]    y_q, y_d;
  logic [W-1:0]    res_q, res_d;

  logic [W:0]      opa, opb;
  logic [W+1:0]    sum;

  // the one adder: accumulate for multiply, trial subtract for divide
  always_comb begin
    if (mul_q) begin
      opa = {1'b0, acc_q};
      opb = {1'b0, x_q};
      sum = {1'b0, opa} + {1'b0, opb};
    end else begin
      opa = {acc_q, x_q[W-1]};
      opb = {1'b0, y_q};
      sum = {1'b0, opa} + ({1'b0, opb} ^ {(W+2){1'b1}}) + (W+2)'(1);
    end
  end

  always_comb begin
    busy_d = busy_q;
    fix_d  = 1'b0;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    mul_d  = mul_q;
    neg_d  = neg_q;
    acc_d  = acc_q;
    x_d    = x_q;
    y_d    = y_q;
    res_d  = res_q;
    if (req_i.start) begin
      unique case (req_i.opcode)
        accalu_pkg::OP_ADD: begin
          res_d  = req_i.a + req_i.b;
          done_d = 1'b1;
        end
        accalu_pkg::OP_SUB: begin
          res_d  = req_i.a - req_i.b;
          done_d = 1'b1;
        end
        accalu_pkg::OP_MUL: begin
          busy_d = 1'b1;
          cnt_d  = '0;
          mul_d  = 1'b1;
          acc_d  = '0;
          x_d    = req_i.a;
          y_d    = req_i.b;
        end
        default: begin
          busy_d = 1'b1;
          cnt_d  = '0;
          mul_d  = 1'b0;
          neg_d  = req_i.a[W-1] ^ req_i.b[W-1];
          acc_d  = '0;
          x_d    = req_i.a[W-1] ? (W'(0) - req_i.a) : req_i.a;
          y_d    = req_i.b[W-1] ? (W'(0) - req_i.b) : req_i.b;
        end
      endcase
    end else if (busy_q) begin
      if (mul_q) begin
        if (y_q[0]) acc_d = sum[W-1:0];
        x_d = {x_q[W-2:0], 1'b0};
        y_d = {1'b0, y_q[W-1:1]};
      end else begin
        if (!sum[W+1]) begin
          acc_d = sum[W-1:0];
          x_d   = {x_q[W-2:0], 1'b1};
        end else begin
          acc_d = opa[W-1:0];
          x_d   = {x_q[W-2:0], 1'b0};
        end
      end
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(accalu_pkg::Steps - 1)) begin
        busy_d = 1'b0;
        fix_d  = 1'b1;
      end
    end else if (fix_q) begin
      // sign fix for the quotient; most negative / -1 wraps naturally
      res_d  = mul_q ? acc_q : (neg_q ? (W'(0) - x_q) : x_q);
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      mul_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      fix_q  <= fix_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      mul_q  <= mul_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
    res_q <= res_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

endmodule
`default_nettype wire

// ===== hdl/accalu_mem.sv =====
`default_nettype none
module accalu_mem #(
  parameter int unsigned DEPTH = accalu_pkg::DefaultDepth,
  parameter int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [IDX_W-1:0]            waddr_i,
  input  wire logic [accalu_pkg::DataW-1:0] wdata_i,
  input  wire logic                        re_i,
  input  wire logic [IDX_W-1:0]            raddr_i,
  output      logic [accalu_pkg::DataW-1:0] rdata_o
);

  logic [accalu_pkg::DataW-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== hdl/accumulator_alu_with_undo_stack.sv =====
// Accumulator calculator with an undo history of DEPTH 32-bit entries.
// Input channel: in_valid_i / in_stall_o carrying command, opcode, operand and
// undo_count; a request is taken when valid is high and stall is low.
// Output channel: out_valid_o / out_stall_i carrying top_value, has_value,
// depth_now and status; one result per request, in order.
// One request is in flight at a time: in_stall_o stays high from acceptance
// until its result has been taken.
// From acceptance, start, unused commands, rejected applies and an undo down to
// empty go straight to S_OUT; add/subtract wait for the unit; an undo that
// leaves entries first does one history read; multiply and divide wait on the
// shared adder working one bit per cycle over 32 steps.
// While the receiver stalls, the result is held unchanged and no new request
// is taken. Reset empties the history (depth zero, top zero); stored entries
// are not cleared, only the count.
`default_nettype none
`include "accumulator_alu_with_undo_stack_macros.svh"
module accumulator_alu_with_undo_stack #(
  parameter int unsigned DEPTH = accalu_pkg::DefaultDepth
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output      logic                            in_stall_o,
  input  wire logic [1:0]                      command_i,
  input  wire logic [1:0]                      opcode_i,
  input  wire logic signed [31:0]              operand_i,
  input  wire logic [8:0]                      undo_count_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  output      logic signed [31:0]              top_value_o,
  output      logic                            has_value_o,
  output      logic [8:0]                      depth_now_o,
  output      logic [1:0]                      status_o
);

  localparam int unsigned W     = accalu_pkg::DataW;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FW    = accalu_pkg::FieldCntW;
  localparam int unsigned CMP_W = (CNT_W > FW) ? CNT_W : FW;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_UNIT     = 3'd1;
  localparam logic [2:0] S_RD_ISSUE = 3'd2;
  localparam logic [2:0] S_RD_WAIT  = 3'd3;
  localparam logic [2:0] S_OUT      = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [W-1:0]     top_q, top_d;
  logic [1:0]       status_q, status_d;

  logic             in_acc;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [W-1:0]     mem_wdata, mem_rdata;
  logic [CMP_W-1:0] undo_ext, cnt_ext;

  accalu_pkg::alu_req_t alu_req;
  accalu_pkg::alu_rsp_t alu_rsp;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign undo_ext   = CMP_W'(undo_count_i);
  assign cnt_ext    = CMP_W'(count_q);

  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    top_d          = top_q;
    status_d       = status_q;
    mem_we         = 1'b0;
    mem_waddr      = count_q[IDX_W-1:0];
    mem_wdata      = alu_rsp.result;
    mem_re         = 1'b0;
    mem_raddr      = IDX_W'(count_q - CNT_W'(1));
    alu_req.start  = 1'b0;
    alu_req.opcode = opcode_i;
    alu_req.a      = top_q;
    alu_req.b      = operand_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          status_d = accalu_pkg::ST_OK;
          state_d  = S_OUT;
          unique case (command_i)
            accalu_pkg::CMD_START: begin
              mem_we    = 1'b1;
              mem_waddr = '0;
              mem_wdata = operand_i;
              count_d   = CNT_W'(1);
              top_d     = operand_i;
            end
            accalu_pkg::CMD_APPLY: begin
              priority if (count_q == '0) begin
                status_d = accalu_pkg::ST_EMPTY;
              end else if (opcode_i == accalu_pkg::OP_DIV && operand_i == '0) begin
                status_d = accalu_pkg::ST_DIV0;
              end else if (count_q == CNT_W'(DEPTH)) begin
                status_d = accalu_pkg::ST_FULL;
              end else begin
                alu_req.start = 1'b1;
                state_d       = S_UNIT;
              end
            end
            accalu_pkg::CMD_UNDO: begin
              if (undo_ext >= cnt_ext) begin
                count_d = '0;
                top_d   = '0;
              end else begin
                count_d = CNT_W'(cnt_ext - undo_ext);
                state_d = S_RD_ISSUE;
              end
            end
            default: ;
          endcase
        end
      end
      S_UNIT: begin
        if (alu_rsp.done) begin
          mem_we  = 1'b1;
          count_d = count_q + CNT_W'(1);
          top_d   = alu_rsp.result;
          state_d = S_OUT;
        end
      end
      S_RD_ISSUE: begin
        mem_re  = 1'b1;
        state_d = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        top_d   = mem_rdata;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      top_q    <= '0;
      status_q <= accalu_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      top_q    <= top_d;
      status_q <= status_d;
    end
  end

  accalu_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  accalu_mem #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o = (state_q == S_OUT);
  assign top_value_o = top_q;
  assign has_value_o = (count_q != '0);
  assign depth_now_o = FW'(count_q);
  assign status_o    = status_q;

  `ACCALU_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH), "history count above depth")
  `ACCALU_ASSERT_IMP(a_done_in_unit, alu_rsp.done, state_q == S_UNIT, "unit done outside wait")
  `ACCALU_ASSERT_IMP(a_empty_top_zero, count_q == '0, top_q == '0, "empty history, top not zero")
  `ACCALU_ASSERT_NEXT(a_push_grows, state_q == S_UNIT && alu_rsp.done,
                      count_q == $past(count_q) + CNT_W'(1) && out_valid_o,
                      "push did not grow history")

endmodule
`default_nettype wire
